// ----- rtl/erp_pkg.sv -----
// ----------------------------------------------------------------------------
// erp_pkg
// Shared widths and controller/datapath command and status types for the
// rhythm pattern unit.
// ----------------------------------------------------------------------------
package erp_pkg;

    localparam int MAX_STEPS = 64;
    localparam int STEP_W    = 7;
    localparam int HIT_W     = 8;
    localparam int ROT_W     = 8;
    localparam int PAT_W     = MAX_STEPS;
    localparam int POS_W     = $clog2(MAX_STEPS);
    localparam int BIT_W     = $clog2(ROT_W);

    typedef struct packed {
        logic load;
        logic mod_step;
        logic gen_init;
        logic gen_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mod_last;
        logic gen_done;
    } t_dp_sts;

endpackage

// ----- rtl/erp_in_if.sv -----
// ----------------------------------------------------------------------------
// erp_in_if
// Request channel: step count, hit count and rotation.
// ----------------------------------------------------------------------------
interface erp_in_if import erp_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [STEP_W-1:0] step_count;
    logic [HIT_W-1:0]  hit_count;
    logic [ROT_W-1:0]  rotate_by;

    modport source (output valid, output step_count, output hit_count,
                    output rotate_by, input ready);
    modport sink   (input valid, input step_count, input hit_count,
                    input rotate_by, output ready);

endinterface

// ----- rtl/erp_out_if.sv -----
// ----------------------------------------------------------------------------
// erp_out_if
// Result channel: one pattern word per request.
// ----------------------------------------------------------------------------
interface erp_out_if import erp_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [PAT_W-1:0] pattern_bits;

    modport source (output valid, output pattern_bits, input ready);
    modport sink   (input valid, input pattern_bits, output ready);

endinterface

// ----- rtl/erp_datapath.sv -----
// ----------------------------------------------------------------------------
// erp_datapath
// Rotation remainder by shift-subtract, then one step per cycle of the
// hit spreading accumulator, writing hits at the rotated position.
// ----------------------------------------------------------------------------
module erp_datapath import erp_pkg::*; (
    input  logic              i_clk,
    input  t_dp_cmd           i_cmd,
    input  logic [STEP_W-1:0] i_step_count,
    input  logic [HIT_W-1:0]  i_hit_count,
    input  logic [ROT_W-1:0]  i_rotate_by,
    output t_dp_sts           o_sts,
    output logic [PAT_W-1:0]  o_pattern_bits
);

    logic [STEP_W-1:0] r_steps, n_steps;
    logic [HIT_W-1:0]  r_hits,  n_hits;
    logic [ROT_W-1:0]  r_rot,   n_rot;
    logic [ROT_W-1:0]  r_rem,   n_rem;
    logic [BIT_W-1:0]  r_bit,   n_bit;
    logic [HIT_W-1:0]  r_diff,  n_diff;
    logic [STEP_W-1:0] r_idx,   n_idx;
    logic [POS_W-1:0]  r_wpos,  n_wpos;
    logic [PAT_W-1:0]  r_pat,   n_pat;
    logic [PAT_W-1:0]  r_out,   n_out;

    logic [STEP_W-1:0] steps_sat;
    logic [ROT_W-1:0]  rem_shift;
    logic              hit;
    logic [HIT_W:0]    diff_sum;
    logic [STEP_W-1:0] wpos_inc;

    assign steps_sat = (i_step_count > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                           : i_step_count;
    assign rem_shift = {r_rem[ROT_W-2:0], r_rot[ROT_W-1]};
    assign hit       = (r_diff < r_hits);
    assign diff_sum  = {1'b0, r_diff} + (hit ? (HIT_W+1)'(r_steps) : '0)
                       - {1'b0, r_hits};
    assign wpos_inc  = STEP_W'(r_wpos) + STEP_W'(1);

    always_comb begin
        n_steps = r_steps;
        n_hits  = r_hits;
        n_rot   = r_rot;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_diff  = r_diff;
        n_idx   = r_idx;
        n_wpos  = r_wpos;
        n_pat   = r_pat;
        n_out   = r_out;
        if (i_cmd.load) begin
            n_steps = steps_sat;
            // more hits than steps gives an empty pattern
            n_hits  = (i_hit_count > HIT_W'(steps_sat)) ? '0 : i_hit_count;
            n_rot   = i_rotate_by;
            n_rem   = '0;
            n_bit   = BIT_W'(ROT_W - 1);
        end
        if (i_cmd.mod_step) begin
            n_rem = (rem_shift >= ROT_W'(r_steps)) ? rem_shift - ROT_W'(r_steps)
                                                   : rem_shift;
            n_rot = {r_rot[ROT_W-2:0], 1'b0};
            n_bit = r_bit - BIT_W'(1);
        end
        if (i_cmd.gen_init) begin
            n_diff = '0;
            n_idx  = '0;
            n_wpos = r_rem[POS_W-1:0];
            n_pat  = '0;
        end
        if (i_cmd.gen_step) begin
            if (hit) begin
                n_pat[r_wpos] = 1'b1;
            end
            n_diff = diff_sum[HIT_W-1:0];
            n_idx  = r_idx + STEP_W'(1);
            n_wpos = (wpos_inc == r_steps) ? '0 : wpos_inc[POS_W-1:0];
        end
        if (i_cmd.out_load) begin
            n_out = r_pat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps <= n_steps;
        r_hits  <= n_hits;
        r_rot   <= n_rot;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_diff  <= n_diff;
        r_idx   <= n_idx;
        r_wpos  <= n_wpos;
        r_pat   <= n_pat;
        r_out   <= n_out;
    end

    assign o_sts.mod_last = (r_bit == '0);
    assign o_sts.gen_done = (r_idx == r_steps);
    assign o_pattern_bits = r_out;

endmodule

// ----- rtl/erp_ctrl.sv -----
// ----------------------------------------------------------------------------
// erp_ctrl
// Sequencer for one request: remainder, setup, step walk, result hand-off.
// ----------------------------------------------------------------------------
module erp_ctrl import erp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_INIT = 3'd2;
    localparam logic [2:0] S_GEN  = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.gen_init = 1'b1;
                n_state        = S_GEN;
            end
            S_GEN, S_HOLD: begin
                if (!i_sts.gen_done) begin
                    o_cmd.gen_step = 1'b1;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_MOD))
        else $error("accepted request did not start remainder");

    a_mod_to_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && i_sts.mod_last) |=> (r_state == S_INIT))
        else $error("remainder did not end after last bit");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_out_valid && r_state == S_IDLE))
        else $error("result load did not raise valid");

    a_hold_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && r_out_valid && !i_out_ready) |=> (r_state == S_HOLD))
        else $error("left hold while result pending");

endmodule

// ----- rtl/euclidean_rhythm_pattern_unit.sv -----
// ----------------------------------------------------------------------------
// euclidean_rhythm_pattern_unit
// Spreads hits evenly over up to MAX_STEPS steps and rotates the pattern.
//
//   port    dir  payload                                handshake
//   i_req   in   step_count[6:0] hit_count[7:0]
//                rotate_by[7:0]                         valid/ready
//   o_rsp   out  pattern_bits[63:0]                     valid/ready
//
// A request runs through the accept, the remainder (one rotation bit per
// step), a setup step and the step walk over the step count saturated at
// MAX_STEPS, one step per cycle. Reset clears the sequencer and the result
// valid flag. A stalled result holds in the output register; the next
// request is taken and runs, and waits at its end until that register frees.
// ----------------------------------------------------------------------------
module euclidean_rhythm_pattern_unit import erp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    erp_in_if.sink    i_req,
    erp_out_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    erp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    erp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_step_count   (i_req.step_count),
        .i_hit_count    (i_req.hit_count),
        .i_rotate_by    (i_req.rotate_by),
        .o_sts          (sts),
        .o_pattern_bits (o_rsp.pattern_bits)
    );

endmodule
